// ===== hdl/chti_pkg.sv =====
package chti_pkg;

    localparam int NUM_BUCKETS = 7;
    localparam int POOL_SIZE   = 64;
    localparam int VALUE_W     = 16;
    localparam int BKT_W       = 3;
    localparam int PTR_MAX_W   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int HASH_CHUNKS = (VALUE_W + 2) / 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REFUSED  = 2'd1;
    localparam logic [1:0] STATUS_ENTRY    = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
        logic [BKT_W-1:0]   bucket;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] entry_value;
        logic [BKT_W-1:0]   entry_bucket;
        logic               last;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REFUSE,
        OP_DUMP,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [VALUE_W-1:0]   value;
        logic [BKT_W-1:0]     bucket;
        logic [PTR_MAX_W-1:0] node;
        logic [PTR_MAX_W-1:0] tail;
        logic                 link_prev;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // value mod 7: 8 == 1 (mod 7), so fold octal digits, then one correction
    function automatic logic [BKT_W-1:0] hash7(input logic [VALUE_W-1:0] v);
        logic [3*HASH_CHUNKS-1:0] vx;
        logic [5:0]               s1;
        logic [3:0]               s2;
        vx = (3*HASH_CHUNKS)'(v);
        s1 = '0;
        for (int i = 0; i < HASH_CHUNKS; i++)
        begin
            s1 = s1 + 6'(vx[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return BKT_W'(s2);
    endfunction

endpackage

// ===== hdl/chti_queue.sv =====
module chti_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  chti_pkg::job_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output chti_pkg::job_t  rd_data,
    output logic            empty
);

    localparam int DEPTH = chti_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    chti_pkg::job_t slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

// ===== hdl/chti_front.sv =====
module chti_front #(
    parameter int POOL_SIZE = chti_pkg::POOL_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  chti_pkg::in_word_t item,
    output logic               full,
    input  logic               q_full,
    output logic               q_wr,
    output chti_pkg::job_t     q_data
);

    localparam int NB     = chti_pkg::NUM_BUCKETS;
    localparam int PTR_W  = $clog2(POOL_SIZE);
    localparam int USED_W = $clog2(POOL_SIZE + 1);
    localparam int PMW    = chti_pkg::PTR_MAX_W;
    localparam int BKT_W  = chti_pkg::BKT_W;

    logic              head_valid_reg [NB];
    logic [PTR_W-1:0]  head_ptr_reg   [NB];
    logic [PTR_W-1:0]  tail_ptr_reg   [NB];
    logic [USED_W-1:0] used_reg;

    logic             accept;
    logic [BKT_W-1:0] hash;
    logic [BKT_W-1:0] bsel;
    logic             bsel_ok;
    logic             pool_full;
    logic [PTR_W-1:0] node;
    logic             do_insert;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign hash      = chti_pkg::hash7(item.value);
    assign bsel      = item.bucket;
    assign bsel_ok   = (32'(bsel) < NB);
    assign pool_full = (used_reg == USED_W'(POOL_SIZE));
    assign node      = used_reg[PTR_W-1:0];
    assign do_insert = accept && (item.command == chti_pkg::CMD_INSERT) && !pool_full;

    always_comb
    begin
        q_wr             = accept;
        q_data.value     = item.value;
        q_data.bucket    = hash;
        q_data.node      = PMW'(node);
        q_data.tail      = PMW'(tail_ptr_reg[hash]);
        q_data.link_prev = head_valid_reg[hash];
        q_data.op        = chti_pkg::OP_INSERT;
        if (item.command == chti_pkg::CMD_INSERT)
        begin
            if (pool_full)
            begin
                q_data.op = chti_pkg::OP_REFUSE;
            end
        end
        else
        begin
            q_data.bucket    = bsel;
            q_data.link_prev = 1'b0;
            q_data.op        = chti_pkg::OP_EMPTY;
            if (bsel_ok)
            begin
                q_data.node = PMW'(head_ptr_reg[bsel]);
                q_data.tail = PMW'(tail_ptr_reg[bsel]);
                if (head_valid_reg[bsel])
                begin
                    q_data.op = chti_pkg::OP_DUMP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < NB; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
        end
        else if (do_insert)
        begin
            used_reg             <= used_reg + 1'b1;
            head_valid_reg[hash] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            tail_ptr_reg[hash] <= node;
            if (!head_valid_reg[hash])
            begin
                head_ptr_reg[hash] <= node;
            end
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= POOL_SIZE)
        else $error("node count past pool size");

endmodule

// ===== hdl/chti_back.sv =====
module chti_back #(
    parameter int POOL_SIZE = chti_pkg::POOL_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  chti_pkg::job_t      job,
    output logic                job_take,
    output chti_pkg::out_word_t result,
    output logic                empty,
    input  logic                pop
);

    localparam int PTR_W   = $clog2(POOL_SIZE);
    localparam int VALUE_W = chti_pkg::VALUE_W;
    localparam int BKT_W   = chti_pkg::BKT_W;

    logic [VALUE_W-1:0] value_mem [POOL_SIZE];
    logic [PTR_W-1:0]   link_mem  [POOL_SIZE];

    chti_pkg::back_state_t state_reg, state_next;
    logic [PTR_W-1:0]      cur_reg, cur_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [BKT_W-1:0]      bucket_reg, bucket_next;
    logic                  out_valid_reg, out_valid_next;
    chti_pkg::out_word_t   out_reg, out_next;
    logic [VALUE_W-1:0]    val_rd_reg;
    logic [PTR_W-1:0]      link_rd_reg;

    logic               out_free;
    logic               val_we;
    logic               link_we;
    logic [PTR_W-1:0]   link_waddr;
    logic [PTR_W-1:0]   job_node;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign job_node = job.node[PTR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        tail_next      = tail_reg;
        bucket_next    = bucket_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        job_take       = 1'b0;
        val_we         = 1'b0;
        link_we        = 1'b0;
        link_waddr     = job.tail[PTR_W-1:0];

        unique case (state_reg)
            chti_pkg::BK_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    job_take              = 1'b1;
                    out_next.entry_value  = job.value;
                    out_next.entry_bucket = job.bucket;
                    out_next.last         = 1'b1;
                    unique case (job.op)
                        chti_pkg::OP_INSERT:
                        begin
                            val_we          = 1'b1;
                            link_we         = job.link_prev;
                            out_next.status = chti_pkg::STATUS_INSERTED;
                            out_valid_next  = 1'b1;
                        end
                        chti_pkg::OP_REFUSE:
                        begin
                            out_next.status = chti_pkg::STATUS_REFUSED;
                            out_valid_next  = 1'b1;
                        end
                        chti_pkg::OP_EMPTY:
                        begin
                            out_next.status      = chti_pkg::STATUS_EMPTY;
                            out_next.entry_value = '0;
                            out_valid_next       = 1'b1;
                        end
                        chti_pkg::OP_DUMP:
                        begin
                            out_next    = out_reg;
                            cur_next    = job_node;
                            tail_next   = job.tail[PTR_W-1:0];
                            bucket_next = job.bucket;
                            state_next  = chti_pkg::BK_READ;
                        end
                        default:
                        begin
                            out_next = out_reg;
                        end
                    endcase
                end
            end
            chti_pkg::BK_READ:
            begin
                state_next = chti_pkg::BK_EMIT;
            end
            chti_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = chti_pkg::STATUS_ENTRY;
                    out_next.entry_value  = val_rd_reg;
                    out_next.entry_bucket = bucket_reg;
                    out_next.last         = (cur_reg == tail_reg);
                    if (cur_reg == tail_reg)
                    begin
                        state_next = chti_pkg::BK_IDLE;
                    end
                    else
                    begin
                        cur_next   = link_rd_reg;
                        state_next = chti_pkg::BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = chti_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chti_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        tail_reg   <= tail_next;
        bucket_reg <= bucket_next;
        out_reg    <= out_next;
    end

    // node pool
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[job_node] <= job.value;
        end
        val_rd_reg <= value_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= job_node;
        end
        link_rd_reg <= link_mem[cur_reg];
    end

    a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chti_pkg::BK_EMIT) |->
            ($past(state_reg) == chti_pkg::BK_READ || $past(state_reg) == chti_pkg::BK_EMIT))
        else $error("entry emitted without a pool read");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> (state_reg == chti_pkg::BK_IDLE) && job_valid && out_free)
        else $error("job taken outside idle");

endmodule

// ===== hdl/chained_hash_table_insert_dump.sv =====
// Insert or refusal result: the accepted word passes through the job queue and the output register.
// Dump: the job passes through the job queue, then each entry through BK_READ, BK_EMIT
// and the output register, set by the registered read of the node pool on each chain step.
// Throughput: one insert per cycle while results are popped and no dump runs; a dump holds the back end per entry.
// Reset: async active low; all buckets empty, node pool count zero, queue and output empty.
module chained_hash_table_insert_dump #(
    parameter int POOL_SIZE = chti_pkg::POOL_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  chti_pkg::in_word_t  item,
    input  logic                pop,
    output logic                empty,
    output chti_pkg::out_word_t result
);

    chti_pkg::job_t q_wr_data;
    chti_pkg::job_t q_rd_data;
    logic           q_wr;
    logic           q_full;
    logic           q_rd;
    logic           q_empty;

    chti_front #(
        .POOL_SIZE (POOL_SIZE)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    chti_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    chti_back #(
        .POOL_SIZE (POOL_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (q_rd_data),
        .job_take  (q_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
